@@ hdl/agw_pkg.sv @@
// Package for the aggregation walker: payload types, command, direction and register codes,
// the controller state type and small helper functions.
// Depends on nothing; every other file imports it.
`default_nettype none

package agw_pkg;

  localparam int COORD_W = 9;
  localparam int COUNT_W = 18;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t COUNT_MAX = '1;
  localparam coord_t FIELD_RESET = 9'd511;

  // Command codes.
  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Direction codes; up is y+1.
  localparam logic [2:0] DIR_UP_LEFT    = 3'd0;
  localparam logic [2:0] DIR_UP         = 3'd1;
  localparam logic [2:0] DIR_UP_RIGHT   = 3'd2;
  localparam logic [2:0] DIR_LEFT       = 3'd3;
  localparam logic [2:0] DIR_RIGHT      = 3'd4;
  localparam logic [2:0] DIR_DOWN_LEFT  = 3'd5;
  localparam logic [2:0] DIR_DOWN       = 3'd6;
  localparam logic [2:0] DIR_DOWN_RIGHT = 3'd7;

  // Register index as decoded from paddr[2].
  localparam logic REG_FIELD_WIDTH  = 1'b0;
  localparam logic REG_FIELD_HEIGHT = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [2:0] direction;
    coord_t     respawn_x;
    coord_t     respawn_y;
    coord_t     spawn_x;
    coord_t     spawn_y;
  } agw_in_t;

  typedef struct packed {
    coord_t walker_x;
    coord_t walker_y;
    logic   stuck;
    coord_t stuck_x;
    coord_t stuck_y;
    count_t cluster_count;
  } agw_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RD_LO,
    S_RD_HI,
    S_RD_MID,
    S_WB
  } agw_state_t;

  // Two's complement step in x for a direction code.
  function automatic logic [1:0] dir_dx(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      DIR_UP_LEFT, DIR_LEFT, DIR_DOWN_LEFT:    r = 2'b11;
      DIR_UP_RIGHT, DIR_RIGHT, DIR_DOWN_RIGHT: r = 2'b01;
      default:                                 r = 2'b00;
    endcase
    return r;
  endfunction

  // Two's complement step in y for a direction code.
  function automatic logic [1:0] dir_dy(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      DIR_UP_LEFT, DIR_UP, DIR_UP_RIGHT:         r = 2'b01;
      DIR_DOWN_LEFT, DIR_DOWN, DIR_DOWN_RIGHT:   r = 2'b11;
      default:                                   r = 2'b00;
    endcase
    return r;
  endfunction

  // Saturate a coordinate to one below the field size (zero for a zero size).
  function automatic coord_t clamp_below(input coord_t v, input coord_t size);
    coord_t lim;
    lim = (size == '0) ? '0 : size - coord_t'(1);
    return (v > lim) ? lim : v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/agw_ifs.sv @@
// Valid/ready channel interfaces for the aggregation walker's step and result transactions.
// Depends on agw_pkg for the payload types.
`default_nettype none

interface agw_in_if;
  import agw_pkg::*;
  logic    valid;
  logic    ready;
  agw_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface agw_out_if;
  import agw_pkg::*;
  logic     valid;
  logic     ready;
  agw_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/aggregation_walker_step.sv @@
// Aggregation walker: a step transaction passes through three row reads of the map memory
// (S_RD_LO, S_RD_HI, S_RD_MID) and a read-modify-write (S_WB) before its result is valid;
// a clear sweeps every row. One transaction is in flight at a time: the next is taken
// only in S_IDLE and given a free result register. Synchronous active-low reset clears the
// walker, counter and control state and sets both field sizes to 511; the map reads as empty
// until the first clear, so no clearing pass runs after reset.
`default_nettype none

module aggregation_walker_step #(
  parameter int GRID_SIZE = 512
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  agw_in_if.sink                               in_ch,
  agw_out_if.source                            out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [agw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [agw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [agw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import agw_pkg::*;

  localparam int GW = $clog2(GRID_SIZE);
  // Neighbour coordinates span -1 to 512 and must also hold GRID_SIZE itself.
  localparam int NW = (GW > 10) ? GW + 1 : 11;

  typedef logic [GRID_SIZE-1:0] row_t;
  typedef logic [NW-1:0]        ncoord_t;

  function automatic logic in_grid(input ncoord_t v);
    return !v[NW-1] && (v < ncoord_t'(GRID_SIZE));
  endfunction

  // Configuration registers and the APB-style port.
  coord_t field_w_r, field_h_r;
  logic   cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_w_r <= FIELD_RESET;
      field_h_r <= FIELD_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_FIELD_WIDTH) begin
        field_w_r <= pwdata[COORD_W-1:0];
      end else begin
        field_h_r <= pwdata[COORD_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_FIELD_WIDTH:  prdata = CFG_DATA_W'(field_w_r);
      REG_FIELD_HEIGHT: prdata = CFG_DATA_W'(field_h_r);
      default:          prdata = '0;
    endcase
  end

  // Control and walker state.
  agw_state_t       state_r, state_nxt;
  coord_t           walker_x_r, walker_y_r;
  coord_t           spawn_x_r, spawn_y_r;
  count_t           count_r;
  logic             map_live_r;
  logic             rd_ok_r;
  logic             hit_r;
  logic [GW-1:0]    clr_row_r;
  logic             out_valid_r;
  agw_out_t         out_data_r;

  // Occupancy map, one row per word.
  row_t             map_mem [GRID_SIZE];
  row_t             rdata_r;
  logic             mem_we;
  logic [GW-1:0]    mem_waddr;
  row_t             mem_wdata;
  logic [GW-1:0]    mem_raddr;

  logic             in_acc;
  logic [1:0]       dx, dy;
  logic [10:0]      nx_w, ny_w;
  logic             leave;
  coord_t           step_x, step_y;

  ncoord_t          cx, cy, xm, xp, ym, yp, rd_row;
  logic             rd_ok_nxt;
  logic             window_hit, hit_all;
  logic             clr_last;
  logic             fin_clear, fin_step;
  coord_t           seed_x, seed_y;
  count_t           count_inc;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Candidate walker move and the field check.
  always_comb begin
    dx     = dir_dx(in_ch.data.direction);
    dy     = dir_dy(in_ch.data.direction);
    nx_w   = {2'b00, walker_x_r} + {{9{dx[1]}}, dx};
    ny_w   = {2'b00, walker_y_r} + {{9{dy[1]}}, dy};
    leave  = nx_w[10] || ny_w[10] ||
             (nx_w[9:0] > {1'b0, field_w_r}) || (ny_w[9:0] > {1'b0, field_h_r});
    step_x = leave ? clamp_below(in_ch.data.respawn_x, field_w_r) : nx_w[COORD_W-1:0];
    step_y = leave ? clamp_below(in_ch.data.respawn_y, field_h_r) : ny_w[COORD_W-1:0];
  end

  // Neighbourhood coordinates around the walker's new cell.
  assign cx = ncoord_t'(walker_x_r);
  assign cy = ncoord_t'(walker_y_r);
  assign xm = cx - ncoord_t'(1);
  assign xp = cx + ncoord_t'(1);
  assign ym = cy - ncoord_t'(1);
  assign yp = cy + ncoord_t'(1);

  // Three cells of the row read in the previous cycle.
  assign window_hit = rd_ok_r && (
                        (in_grid(xm) && rdata_r[xm[GW-1:0]]) ||
                        (in_grid(cx) && rdata_r[cx[GW-1:0]]) ||
                        (in_grid(xp) && rdata_r[xp[GW-1:0]]));
  assign hit_all    = hit_r || window_hit;

  assign seed_x    = field_w_r >> 1;
  assign seed_y    = field_h_r >> 1;
  assign clr_last  = (clr_row_r == GW'(GRID_SIZE - 1));
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + count_t'(1);

  // Next state and memory control.
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = clr_row_r;
    mem_wdata = '0;
    rd_row    = cy;
    fin_clear = 1'b0;
    fin_step  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.data.cmd == CMD_CLEAR) ? S_CLEAR : S_RD_LO;
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        if (in_grid(ncoord_t'(seed_x)) && in_grid(ncoord_t'(seed_y)) &&
            (ncoord_t'(clr_row_r) == ncoord_t'(seed_y))) begin
          mem_wdata = row_t'(1) << seed_x;
        end
        if (clr_last) begin
          fin_clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD_LO: begin
        rd_row    = ym;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        rd_row    = yp;
        state_nxt = S_RD_MID;
      end
      S_RD_MID: begin
        rd_row    = cy;
        state_nxt = S_WB;
      end
      S_WB: begin
        // The centre row has just arrived: set the walker's bit and, on a hit, write it back.
        fin_step  = 1'b1;
        mem_waddr = cy[GW-1:0];
        mem_wdata = rdata_r | (row_t'(1) << walker_x_r);
        mem_we    = hit_all && in_grid(cx) && in_grid(cy);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign mem_raddr = rd_row[GW-1:0];
  assign rd_ok_nxt = map_live_r && in_grid(rd_row) &&
                     ((state_r == S_RD_LO) || (state_r == S_RD_HI) || (state_r == S_RD_MID));

  // Map memory with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= map_mem[mem_raddr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Walker, counter and sweep control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walker_x_r  <= '0;
      walker_y_r  <= '0;
      count_r     <= '0;
      map_live_r  <= 1'b0;
      rd_ok_r     <= 1'b0;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ok_r <= rd_ok_nxt;

      if (in_acc) begin
        clr_row_r <= '0;
        if (in_ch.data.cmd == CMD_CLEAR) begin
          walker_x_r <= clamp_below(in_ch.data.spawn_x, field_w_r);
          walker_y_r <= clamp_below(in_ch.data.spawn_y, field_h_r);
        end else begin
          walker_x_r <= step_x;
          walker_y_r <= step_y;
        end
      end else if (state_r == S_CLEAR) begin
        clr_row_r <= clr_row_r + GW'(1);
      end

      if (fin_clear) begin
        count_r    <= count_t'(1);
        map_live_r <= 1'b1;
      end

      if (fin_step && hit_all) begin
        walker_x_r <= spawn_x_r;
        walker_y_r <= spawn_y_r;
        count_r    <= count_inc;
      end

      if (fin_clear || fin_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Transaction payload held for the step, the hit flag and the result register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      spawn_x_r <= clamp_below(in_ch.data.spawn_x, field_w_r);
      spawn_y_r <= clamp_below(in_ch.data.spawn_y, field_h_r);
    end

    if (state_r == S_RD_LO) begin
      hit_r <= 1'b0;
    end else if ((state_r == S_RD_HI) || (state_r == S_RD_MID)) begin
      hit_r <= hit_r || window_hit;
    end

    if (fin_clear) begin
      out_data_r.walker_x      <= walker_x_r;
      out_data_r.walker_y      <= walker_y_r;
      out_data_r.stuck         <= 1'b0;
      out_data_r.stuck_x       <= '0;
      out_data_r.stuck_y       <= '0;
      out_data_r.cluster_count <= count_t'(1);
    end else if (fin_step) begin
      if (hit_all) begin
        out_data_r.walker_x      <= spawn_x_r;
        out_data_r.walker_y      <= spawn_y_r;
        out_data_r.stuck         <= 1'b1;
        out_data_r.stuck_x       <= walker_x_r;
        out_data_r.stuck_y       <= walker_y_r;
        out_data_r.cluster_count <= count_inc;
      end else begin
        out_data_r.walker_x      <= walker_x_r;
        out_data_r.walker_y      <= walker_y_r;
        out_data_r.stuck         <= 1'b0;
        out_data_r.stuck_x       <= '0;
        out_data_r.stuck_y       <= '0;
        out_data_r.cluster_count <= count_r;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the aggregation walker step block.
// Depends on agw_pkg, the agw_in_if/agw_out_if channel interfaces and aggregation_walker_step.
// A built-in predictor of the walker and occupancy map checks every result transaction.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import agw_pkg::*;

  localparam int GRID = 512;
  localparam int DRAIN_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  agw_in_if  in_ch();
  agw_out_if out_ch();

  aggregation_walker_step #(.GRID_SIZE(GRID)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Predicted walker state, register copies and occupancy map.
  coord_t          field_w;
  coord_t          field_h;
  coord_t          walk_x;
  coord_t          walk_y;
  count_t          cluster_n;
  bit [GRID-1:0]   occ_rows [GRID];

  agw_out_t        expected_walks [$];
  int              fail_count;

  // Idling controls for the stimulus and result processes.
  bit              tx_idle_on;
  bit              rx_idle_on;
  int              rx_hold_cycles;

  // Saturate a coordinate to one below the field size.
  function automatic coord_t limit_coord(input coord_t v, input coord_t size);
    coord_t lim;
    lim = (size == '0) ? '0 : coord_t'(size - 1);
    return (v > lim) ? lim : v;
  endfunction

  // Cells off the grid always read as empty.
  function automatic bit occupied(input int x, input int y);
    if (x < 0 || y < 0 || x >= GRID || y >= GRID) return 1'b0;
    return occ_rows[y][x];
  endfunction

  // Advance the predicted walker by one transaction and return its result.
  function automatic agw_out_t advance_walker(input agw_in_t it);
    agw_out_t res;
    int       nx;
    int       ny;
    int       ddx;
    int       ddy;
    bit       hit;
    res = '0;
    if (it.cmd == CMD_CLEAR) begin
      foreach (occ_rows[r]) occ_rows[r] = '0;
      occ_rows[field_h / 2][field_w / 2] = 1'b1;
      cluster_n = count_t'(1);
      walk_x = limit_coord(it.spawn_x, field_w);
      walk_y = limit_coord(it.spawn_y, field_h);
    end else begin
      ddx = 0;
      ddy = 0;
      case (it.direction)
        DIR_UP_LEFT:    begin ddx = -1; ddy =  1; end
        DIR_UP:         begin ddx =  0; ddy =  1; end
        DIR_UP_RIGHT:   begin ddx =  1; ddy =  1; end
        DIR_LEFT:       begin ddx = -1; ddy =  0; end
        DIR_RIGHT:      begin ddx =  1; ddy =  0; end
        DIR_DOWN_LEFT:  begin ddx = -1; ddy = -1; end
        DIR_DOWN:       begin ddx =  0; ddy = -1; end
        DIR_DOWN_RIGHT: begin ddx =  1; ddy = -1; end
        default:        begin ddx =  0; ddy =  0; end
      endcase
      nx = int'(walk_x) + ddx;
      ny = int'(walk_y) + ddy;
      // A walker that leaves the field restarts at the respawn position.
      if (nx < 0 || ny < 0 || nx > int'(field_w) || ny > int'(field_h)) begin
        nx = int'(limit_coord(it.respawn_x, field_w));
        ny = int'(limit_coord(it.respawn_y, field_h));
      end
      walk_x = coord_t'(nx);
      walk_y = coord_t'(ny);
      hit = 1'b0;
      for (int j = -1; j <= 1; j++)
        for (int i = -1; i <= 1; i++)
          if (occupied(nx + i, ny + j)) hit = 1'b1;
      if (hit) begin
        res.stuck   = 1'b1;
        res.stuck_x = walk_x;
        res.stuck_y = walk_y;
        occ_rows[walk_y][walk_x] = 1'b1;
        if (cluster_n != COUNT_MAX) cluster_n = cluster_n + count_t'(1);
        walk_x = limit_coord(it.spawn_x, field_w);
        walk_y = limit_coord(it.spawn_y, field_h);
      end
    end
    res.walker_x      = walk_x;
    res.walker_y      = walk_y;
    res.cluster_count = cluster_n;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic agw_in_t make_walk(input logic cmd, input logic [2:0] dir,
                                        input int rx, input int ry,
                                        input int sx, input int sy);
    agw_in_t it;
    it.cmd       = cmd;
    it.direction = dir;
    it.respawn_x = coord_t'(rx);
    it.respawn_y = coord_t'(ry);
    it.spawn_x   = coord_t'(sx);
    it.spawn_y   = coord_t'(sy);
    return it;
  endfunction

  // A coordinate within a given radius of a centre, kept on the grid.
  function automatic int near_coord(input int centre, input int radius);
    int v;
    v = centre + int'($urandom_range(0, 2 * radius)) - radius;
    if (v < 0) v = 0;
    if (v > GRID - 1) v = GRID - 1;
    return v;
  endfunction

  // Offer one transaction and record its prediction once it is accepted.
  task automatic send_walk(input agw_in_t it);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_walks.insert(expected_walks.size(), advance_walker(it));
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic drain_walks();
    in_ch.valid <= 1'b0;
    while (expected_walks.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One register transfer: setup cycle, then access cycle until pready.
  task automatic reg_transfer(input bit is_write, input logic sel,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic sel, input coord_t want);
    logic [CFG_DATA_W-1:0] rdata;
    reg_transfer(1'b0, sel, '0, rdata);
    if (rdata !== CFG_DATA_W'(want)) begin
      $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
               $time, sel, want, rdata);
      fail_count++;
    end
  endtask

  // Write a field size, optionally with noise above the used bits, and read it back.
  task automatic set_field(input logic sel, input coord_t value, input bit noisy);
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] rdata;
    wdata = noisy ? CFG_DATA_W'($urandom()) : '0;
    wdata[COORD_W-1:0] = value;
    reg_transfer(1'b1, sel, wdata, rdata);
    if (sel == REG_FIELD_WIDTH) field_w = value;
    else field_h = value;
    check_register(sel, value);
  endtask

  task automatic check_field(input string field_name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
      fail_count++;
    end
  endtask

  // Result side: random back-pressure, long hold-offs on request, field-by-field checks.
  initial begin
    agw_out_t exp_walk;
    agw_out_t got;
    int       pause;
    out_ch.ready <= 1'b0;
    pause = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_walks.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %p", $time, got);
          fail_count++;
        end else begin
          exp_walk = expected_walks.pop_front();
          check_field("walker_x", exp_walk.walker_x, got.walker_x);
          check_field("walker_y", exp_walk.walker_y, got.walker_y);
          check_field("stuck", exp_walk.stuck, got.stuck);
          check_field("stuck_x", exp_walk.stuck_x, got.stuck_x);
          check_field("stuck_y", exp_walk.stuck_y, got.stuck_y);
          check_field("cluster_count", exp_walk.cluster_count, got.cluster_count);
        end
      end
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (pause > 0) begin
        out_ch.ready <= 1'b0;
        pause--;
      end else begin
        out_ch.ready <= 1'b1;
        if (rx_idle_on) pause = pick_gap();
      end
    end
  end

  // Steps on an empty map, clearing, seeding and sticking with the reset field size.
  task automatic test_before_clear_and_seed();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_walk(make_walk(CMD_STEP, DIR_DOWN_LEFT, 511, 511, 0, 0));
    send_walk(make_walk(CMD_STEP, DIR_UP_RIGHT, 0, 0, 0, 0));
    send_walk(make_walk(CMD_STEP, DIR_RIGHT, 0, 0, 511, 511));
    send_walk(make_walk(CMD_CLEAR, DIR_UP, 0, 0, 511, 511));
    send_walk(make_walk(CMD_CLEAR, DIR_UP, 0, 0, 255, 254));
    // Landing on the seed itself still counts as sticking.
    send_walk(make_walk(CMD_STEP, DIR_UP, 0, 0, 257, 257));
    send_walk(make_walk(CMD_STEP, DIR_UP_LEFT, 0, 0, 257, 257));
    send_walk(make_walk(CMD_STEP, DIR_DOWN, 0, 0, 257, 257));
    send_walk(make_walk(CMD_STEP, DIR_DOWN_LEFT, 511, 0, 0, 511));
    drain_walks();
  endtask

  // A zero-sized field holds only the origin, so every step leaves and sticks again.
  task automatic test_zero_field();
    set_field(REG_FIELD_WIDTH, '0, 1'b0);
    set_field(REG_FIELD_HEIGHT, '0, 1'b0);
    send_walk(make_walk(CMD_CLEAR, DIR_UP, 511, 511, 511, 511));
    send_walk(make_walk(CMD_STEP, DIR_LEFT, 511, 511, 511, 511));
    send_walk(make_walk(CMD_STEP, DIR_DOWN_RIGHT, 0, 0, 0, 0));
    send_walk(make_walk(CMD_STEP, DIR_UP_RIGHT, 511, 0, 0, 511));
    send_walk(make_walk(CMD_STEP, DIR_RIGHT, 0, 511, 511, 0));
    drain_walks();
  endtask

  // One-wide and one-high fields against the widest other side.
  task automatic test_edge_fields();
    set_field(REG_FIELD_WIDTH, coord_t'(1), 1'b0);
    set_field(REG_FIELD_HEIGHT, coord_t'(511), 1'b0);
    send_walk(make_walk(CMD_CLEAR, DIR_UP, 0, 0, 1, 255));
    send_walk(make_walk(CMD_STEP, DIR_UP_RIGHT, 511, 256, 1, 300));
    send_walk(make_walk(CMD_STEP, DIR_DOWN_LEFT, 0, 0, 511, 511));
    drain_walks();
    set_field(REG_FIELD_WIDTH, coord_t'(511), 1'b0);
    set_field(REG_FIELD_HEIGHT, coord_t'(1), 1'b0);
    send_walk(make_walk(CMD_CLEAR, DIR_UP, 0, 0, 254, 0));
    send_walk(make_walk(CMD_STEP, DIR_DOWN_RIGHT, 256, 511, 0, 0));
    send_walk(make_walk(CMD_STEP, DIR_UP, 0, 0, 511, 511));
    drain_walks();
  endtask

  // Field sizes for a random phase, extremes included.
  function automatic coord_t pick_size();
    case ($urandom_range(0, 5))
      0:       return coord_t'($urandom_range(0, 3));
      1:       return coord_t'($urandom_range(4, 24));
      2:       return coord_t'($urandom_range(25, 120));
      3:       return coord_t'(511);
      4:       return coord_t'($urandom_range(0, 511));
      default: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return coord_t'(1);
          default: return coord_t'(511);
        endcase
      end
    endcase
  endfunction

  // A step whose spawn lies close to the cluster, so the cluster keeps growing.
  function automatic agw_in_t growth_walk(input logic cmd);
    int cx;
    int cy;
    int radius;
    int rx;
    int ry;
    cx = int'(field_w) / 2;
    cy = int'(field_h) / 2;
    radius = 2 + ((cluster_n > count_t'(90)) ? 30 : int'(cluster_n) / 3);
    if ($urandom_range(0, 1) == 0) begin
      rx = near_coord(cx, radius);
      ry = near_coord(cy, radius);
    end else begin
      rx = $urandom_range(0, 511);
      ry = $urandom_range(0, 511);
    end
    return make_walk(cmd, 3'($urandom_range(0, 7)), rx, ry,
                     near_coord(cx, radius), near_coord(cy, radius));
  endfunction

  // Random phases: new field sizes, a clear, then mostly cluster-building steps with noise.
  task automatic test_random_growth();
    int      steps;
    int      r;
    agw_in_t it;
    for (int phase = 0; phase < 16; phase++) begin
      set_field(REG_FIELD_WIDTH, pick_size(), 1'b1);
      set_field(REG_FIELD_HEIGHT, pick_size(), 1'b1);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      send_walk(growth_walk(CMD_CLEAR));
      steps = $urandom_range(40, 70);
      for (int n = 0; n < steps; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          it = make_walk(CMD_CLEAR, 3'($urandom_range(0, 7)), $urandom_range(0, 511),
                         $urandom_range(0, 511), $urandom_range(0, 511),
                         $urandom_range(0, 511));
        end else if (r < 14) begin
          it = make_walk(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                         $urandom_range(0, 511), $urandom_range(0, 511),
                         $urandom_range(0, 511), $urandom_range(0, 511));
        end else begin
          it = growth_walk(CMD_STEP);
        end
        send_walk(it);
      end
      drain_walks();
    end
  endtask

  // The result side holds off for a long stretch while steps keep being offered.
  task automatic test_output_stall();
    set_field(REG_FIELD_WIDTH, coord_t'(12), 1'b0);
    set_field(REG_FIELD_HEIGHT, coord_t'(9), 1'b0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_walk(growth_walk(CMD_CLEAR));
    drain_walks();
    rx_hold_cycles = 300;
    for (int n = 0; n < 40; n++) send_walk(growth_walk(CMD_STEP));
    drain_walks();
  endtask

  // Long stop for a hung run.
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Test sequence.
  initial begin
    int waited;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.data     <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    fail_count     = 0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = 0;
    field_w        = FIELD_RESET;
    field_h        = FIELD_RESET;
    walk_x         = '0;
    walk_y         = '0;
    cluster_n      = '0;
    foreach (occ_rows[r]) occ_rows[r] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_register(REG_FIELD_WIDTH, FIELD_RESET);
    check_register(REG_FIELD_HEIGHT, FIELD_RESET);

    test_before_clear_and_seed();
    test_zero_field();
    test_edge_fields();
    test_random_growth();
    test_output_stall();

    // Wait for outstanding results, then a little longer for stray transactions.
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_walks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_walks.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_walks.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
